@@ rtl/core/assert_macros.svh @@
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset.
`define HRLP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define HRLP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/core/hrlp_pkg.sv @@
package hrlp_pkg;

   localparam int TOKS_PER_ENTRY = 3;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      TK_NONE       = 4'd0,
      TK_METHOD     = 4'd1,
      TK_RESOURCE   = 4'd2,
      TK_PARAM_NAME = 4'd3,
      TK_PARAM_VAL  = 4'd4,
      TK_HDR_NAME   = 4'd5,
      TK_HDR_VAL    = 4'd6,
      TK_BODY       = 4'd7,
      TK_NEW_PARAM  = 4'd8,
      TK_NEW_HDR    = 4'd9
   } token_kind_type;

   typedef enum logic [1:0] {
      ST_RUNNING = 2'd0,
      ST_EARLY   = 2'd1,
      ST_ERROR   = 2'd2,
      ST_END     = 2'd3
   } status_type;

   // one parsed byte: up to three tokens plus the fields common to them
   typedef struct packed {
      logic [1:0]                          count;
      token_kind_type [TOKS_PER_ENTRY-1:0] kinds;
      logic [TOKS_PER_ENTRY-1:0][7:0]      bytes;
      logic [3:0]                          method_code;
      logic [7:0]                          major;
      logic [7:0]                          minor;
      status_type                          status;
   } entry_type;

   localparam int NUM_METHODS = 9;

   localparam logic [7:0] METHOD_NAMES [NUM_METHODS][7] = '{
      '{"G", "E", "T", 8'h0, 8'h0, 8'h0, 8'h0},
      '{"H", "E", "A", "D", 8'h0, 8'h0, 8'h0},
      '{"P", "O", "S", "T", 8'h0, 8'h0, 8'h0},
      '{"P", "U", "T", 8'h0, 8'h0, 8'h0, 8'h0},
      '{"D", "E", "L", "E", "T", "E", 8'h0},
      '{"C", "O", "N", "N", "E", "C", "T"},
      '{"O", "P", "T", "I", "O", "N", "S"},
      '{"T", "R", "A", "C", "E", 8'h0, 8'h0},
      '{"P", "A", "T", "C", "H", 8'h0, 8'h0}
   };

   localparam logic [2:0] METHOD_LENS [NUM_METHODS] = '{
      3'd3, 3'd4, 3'd4, 3'd3, 3'd6, 3'd7, 3'd7, 3'd5, 3'd5
   };

endpackage

@@ rtl/core/hrlp_front.sv @@
module hrlp_front
   import hrlp_pkg::*;
#(
   parameter int MAX_METHOD_CHARS = 7
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_request,
   input  logic       queue_full,
   output logic       push_valid,
   output entry_type  push_entry
);

   localparam int LEN_W = $clog2(MAX_METHOD_CHARS + 2);
   localparam int CMP_N = (MAX_METHOD_CHARS > 7) ? 7 : MAX_METHOD_CHARS;

   typedef enum logic [4:0] {
      PH_BEGIN, PH_METHOD, PH_RES_BEGIN, PH_RES, PH_PAR_BEGIN, PH_PAR_NAME,
      PH_PAR_VALUE, PH_V_H, PH_V_HT, PH_V_HTT, PH_V_HTTP, PH_V_SLASH,
      PH_MAJ, PH_MAJ_LONG, PH_MIN, PH_MIN_LONG, PH_NEWLINE, PH_HDR_BEGIN,
      PH_HDR_SKIP, PH_HDR_NAME, PH_HDR_SEP, PH_HDR_VALUE, PH_HDR_END,
      PH_BODY_BEGIN, PH_BODY
   } phase_type;

   function automatic logic is_ctl(input logic [7:0] c);
      return (c <= 8'd31) || (c == 8'd127);
   endfunction

   function automatic logic is_sep(input logic [7:0] c);
      return c == "(" || c == ")" || c == "<" || c == ">" || c == "@" ||
             c == "," || c == ";" || c == ":" || c == 8'h5c || c == 8'h22 ||
             c == "/" || c == "[" || c == "]" || c == "?" || c == "=" ||
             c == "{" || c == "}" || c == " " || c == 8'h09;
   endfunction

   function automatic logic is_tok(input logic [7:0] c);
      return !c[7] && !is_ctl(c) && !is_sep(c);
   endfunction

   function automatic logic is_dig(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_dig(c) || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] t;
      if (is_dig(c)) t = c - 8'd48;
      else if (c >= "A" && c <= "F") t = c - 8'd55;
      else t = c - 8'd87;
      return t[3:0];
   endfunction

   function automatic logic [7:0] sat_digit(input logic [7:0] v, input logic [7:0] c);
      logic [11:0] r;
      r = {4'd0, v} * 12'd10 + {4'd0, c - 8'd48};
      return (r > 12'd255) ? 8'd255 : r[7:0];
   endfunction

   phase_type       phase_ff, phase_in;
   logic [7:0]      chars_ff [MAX_METHOD_CHARS];
   logic [LEN_W-1:0] len_ff, len_in;
   logic [3:0]      code_ff, code_in, code_lookup;
   logic [7:0]      major_ff, major_in, minor_ff, minor_in;
   logic            seen_ff, seen_in;
   logic [1:0]      pcnt_ff, pcnt_in;
   logic [7:0]      phex_ff, phex_in;
   logic            stopped_ff;
   logic            push_char;
   status_type      adv, status;
   logic [1:0]      cnt;
   token_kind_type [TOKS_PER_ENTRY-1:0] kinds;
   logic [TOKS_PER_ENTRY-1:0][7:0]      bytes;
   logic            feed_en, flush_en, feed_done;
   token_kind_type  pkind;
   logic            accept;
   logic [7:0]      c;
   logic            match;

   assign c         = req_data_byte;
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign push_valid = accept && !stopped_ff;

   // first of the standard methods whose spelling matches exactly
   always_comb begin
      code_lookup = 4'd0;
      for (int i = NUM_METHODS - 1; i >= 0; i--) begin
         match = (len_ff == LEN_W'(METHOD_LENS[i])) &&
                 (int'(METHOD_LENS[i]) <= MAX_METHOD_CHARS);
         for (int k = 0; k < CMP_N; k++) begin
            if (k < int'(METHOD_LENS[i]) && chars_ff[k] != METHOD_NAMES[i][k])
               match = 1'b0;
         end
         if (match) code_lookup = 4'(i + 1);
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      len_in    = len_ff;
      code_in   = code_ff;
      major_in  = major_ff;
      minor_in  = minor_ff;
      seen_in   = seen_ff;
      pcnt_in   = pcnt_ff;
      phex_in   = phex_ff;
      push_char = 1'b0;
      adv       = ST_RUNNING;
      cnt       = 2'd0;
      kinds     = '{default: TK_NONE};
      bytes     = '0;
      feed_en   = 1'b0;
      flush_en  = 1'b0;
      feed_done = 1'b0;
      pkind     = TK_PARAM_NAME;

      case (phase_ff)
         PH_BEGIN: begin
            if (!is_tok(c)) adv = ST_ERROR;
            else begin
               push_char = 1'b1;
               kinds[cnt] = TK_METHOD; bytes[cnt] = c; cnt = cnt + 2'd1;
               phase_in = PH_METHOD;
            end
         end
         PH_METHOD: begin
            if (c == " ") begin
               code_in = code_lookup;
               if (code_lookup == 4'd0) adv = ST_EARLY;
               else phase_in = PH_RES_BEGIN;
            end else if (!is_tok(c)) adv = ST_ERROR;
            else begin
               push_char = 1'b1;
               kinds[cnt] = TK_METHOD; bytes[cnt] = c; cnt = cnt + 2'd1;
            end
         end
         PH_RES_BEGIN: begin
            if (is_ctl(c)) adv = ST_ERROR;
            else begin
               kinds[cnt] = TK_RESOURCE; bytes[cnt] = c; cnt = cnt + 2'd1;
               phase_in = PH_RES;
            end
         end
         PH_RES: begin
            if (c == " ") phase_in = PH_V_H;
            else if (c == "?") phase_in = PH_PAR_BEGIN;
            else if (c == 8'h0d) begin
               // bare request line: HTTP/0.9
               major_in = 8'd0; minor_in = 8'd9; adv = ST_EARLY;
            end else if (is_ctl(c)) adv = ST_ERROR;
            else begin
               kinds[cnt] = TK_RESOURCE; bytes[cnt] = c; cnt = cnt + 2'd1;
            end
         end
         PH_PAR_BEGIN: begin
            if (is_ctl(c)) adv = ST_ERROR;
            else if (c == " ") phase_in = PH_V_H;
            else begin
               kinds[cnt] = TK_NEW_PARAM; bytes[cnt] = 8'd0; cnt = cnt + 2'd1;
               feed_en = 1'b1;
               phase_in = PH_PAR_NAME;
            end
         end
         PH_PAR_NAME, PH_PAR_VALUE: begin
            pkind = (phase_ff == PH_PAR_NAME) ? TK_PARAM_NAME : TK_PARAM_VAL;
            if (c == "=" && phase_ff == PH_PAR_NAME) begin
               flush_en = 1'b1; phase_in = PH_PAR_VALUE;
            end else if (c == "&") begin
               flush_en = 1'b1; phase_in = PH_PAR_BEGIN;
            end else if (c == " ") begin
               flush_en = 1'b1; phase_in = PH_V_H;
            end else if (is_ctl(c)) adv = ST_ERROR;
            else feed_en = 1'b1;
         end
         PH_V_H:     if (c != "H") adv = ST_ERROR; else phase_in = PH_V_HT;
         PH_V_HT:    if (c != "T") adv = ST_ERROR; else phase_in = PH_V_HTT;
         PH_V_HTT:   if (c != "T") adv = ST_ERROR; else phase_in = PH_V_HTTP;
         PH_V_HTTP:  if (c != "P") adv = ST_ERROR; else phase_in = PH_V_SLASH;
         PH_V_SLASH: begin
            if (c != "/") adv = ST_ERROR;
            else begin
               major_in = 8'd0; minor_in = 8'd0; phase_in = PH_MAJ;
            end
         end
         PH_MAJ: begin
            if (!is_dig(c)) adv = ST_ERROR;
            else begin
               major_in = c - 8'd48; phase_in = PH_MAJ_LONG;
            end
         end
         PH_MAJ_LONG: begin
            if (c == ".") phase_in = PH_MIN;
            else if (!is_dig(c)) adv = ST_ERROR;
            else major_in = sat_digit(major_ff, c);
         end
         PH_MIN: begin
            if (!is_dig(c)) adv = ST_ERROR;
            else begin
               minor_in = c - 8'd48; phase_in = PH_MIN_LONG;
            end
         end
         PH_MIN_LONG: begin
            if (c == 8'h0d) phase_in = PH_NEWLINE;
            else if (!is_dig(c)) adv = ST_ERROR;
            else minor_in = sat_digit(minor_ff, c);
         end
         PH_NEWLINE, PH_HDR_END: begin
            if (c != 8'h0a) adv = ST_ERROR; else phase_in = PH_HDR_BEGIN;
         end
         PH_HDR_BEGIN: begin
            if (c == 8'h0d) phase_in = PH_BODY_BEGIN;
            else if (seen_ff && (c == " " || c == 8'h09)) phase_in = PH_HDR_SKIP;
            else if (!is_tok(c)) adv = ST_ERROR;
            else begin
               seen_in = 1'b1;
               kinds[cnt] = TK_NEW_HDR; bytes[cnt] = 8'd0; cnt = cnt + 2'd1;
               kinds[cnt] = TK_HDR_NAME; bytes[cnt] = c; cnt = cnt + 2'd1;
               phase_in = PH_HDR_NAME;
            end
         end
         PH_HDR_SKIP: begin
            if (c == 8'h0d) phase_in = PH_HDR_END;
            else if (c == " " || c == 8'h09) phase_in = PH_HDR_SKIP;
            else if (is_ctl(c)) adv = ST_ERROR;
            else begin
               kinds[cnt] = TK_HDR_VAL; bytes[cnt] = c; cnt = cnt + 2'd1;
               phase_in = PH_HDR_VALUE;
            end
         end
         PH_HDR_NAME: begin
            if (c == ":") phase_in = PH_HDR_SEP;
            else if (!is_tok(c)) adv = ST_ERROR;
            else begin
               kinds[cnt] = TK_HDR_NAME; bytes[cnt] = c; cnt = cnt + 2'd1;
            end
         end
         PH_HDR_SEP: if (c != " ") adv = ST_ERROR; else phase_in = PH_HDR_VALUE;
         PH_HDR_VALUE: begin
            if (c == 8'h0d) phase_in = PH_HDR_END;
            else if (is_ctl(c)) adv = ST_ERROR;
            else begin
               kinds[cnt] = TK_HDR_VAL; bytes[cnt] = c; cnt = cnt + 2'd1;
            end
         end
         PH_BODY_BEGIN: phase_in = PH_BODY;
         PH_BODY: begin
            kinds[cnt] = TK_BODY; bytes[cnt] = c; cnt = cnt + 2'd1;
         end
         default: adv = ST_ERROR;
      endcase

      // held percent characters go out literally
      if (flush_en) begin
         if (pcnt_ff != 2'd0) begin
            kinds[cnt] = pkind; bytes[cnt] = "%"; cnt = cnt + 2'd1;
         end
         if (pcnt_ff == 2'd2) begin
            kinds[cnt] = pkind; bytes[cnt] = phex_ff; cnt = cnt + 2'd1;
         end
         pcnt_in = 2'd0;
      end

      if (feed_en) begin
         if (pcnt_ff == 2'd1) begin
            if (is_hex(c)) begin
               phex_in = c; pcnt_in = 2'd2; feed_done = 1'b1;
            end else begin
               kinds[cnt] = pkind; bytes[cnt] = "%"; cnt = cnt + 2'd1;
               pcnt_in = 2'd0;
            end
         end else if (pcnt_ff == 2'd2) begin
            if (is_hex(c)) begin
               kinds[cnt] = pkind; bytes[cnt] = {hex_val(phex_ff), hex_val(c)};
               cnt = cnt + 2'd1;
               pcnt_in = 2'd0; feed_done = 1'b1;
            end else begin
               kinds[cnt] = pkind; bytes[cnt] = "%"; cnt = cnt + 2'd1;
               kinds[cnt] = pkind; bytes[cnt] = phex_ff; cnt = cnt + 2'd1;
               pcnt_in = 2'd0;
            end
         end else begin
            pcnt_in = 2'd0;
         end
         if (!feed_done) begin
            if (c == "%") pcnt_in = 2'd1;
            else begin
               kinds[cnt] = pkind; bytes[cnt] = c; cnt = cnt + 2'd1;
            end
         end
      end

      status = adv;
      if (adv == ST_RUNNING && req_end_of_request) begin
         status = ST_END;
         if (pcnt_in != 2'd0) begin
            pkind = (phase_in == PH_PAR_VALUE) ? TK_PARAM_VAL : TK_PARAM_NAME;
            kinds[cnt] = pkind; bytes[cnt] = "%"; cnt = cnt + 2'd1;
            if (pcnt_in == 2'd2) begin
               kinds[cnt] = pkind; bytes[cnt] = phex_in; cnt = cnt + 2'd1;
            end
         end
      end

      if (cnt == 2'd0) begin
         kinds[0] = TK_NONE; bytes[0] = 8'd0; cnt = 2'd1;
      end
   end

   always_comb begin
      push_entry.count       = cnt;
      push_entry.kinds       = kinds;
      push_entry.bytes       = bytes;
      push_entry.method_code = code_in;
      push_entry.major       = major_in;
      push_entry.minor       = minor_in;
      push_entry.status      = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_BEGIN;
         len_ff     <= '0;
         code_ff    <= 4'd0;
         major_ff   <= 8'd0;
         minor_ff   <= 8'd0;
         seen_ff    <= 1'b0;
         pcnt_ff    <= 2'd0;
         phex_ff    <= 8'd0;
         stopped_ff <= 1'b0;
      end else if (accept) begin
         if (req_end_of_request) begin
            phase_ff   <= PH_BEGIN;
            len_ff     <= '0;
            code_ff    <= 4'd0;
            major_ff   <= 8'd0;
            minor_ff   <= 8'd0;
            seen_ff    <= 1'b0;
            pcnt_ff    <= 2'd0;
            phex_ff    <= 8'd0;
            stopped_ff <= 1'b0;
         end else if (!stopped_ff) begin
            phase_ff   <= phase_in;
            code_ff    <= code_in;
            major_ff   <= major_in;
            minor_ff   <= minor_in;
            seen_ff    <= seen_in;
            pcnt_ff    <= pcnt_in;
            phex_ff    <= phex_in;
            stopped_ff <= (adv != ST_RUNNING);
            if (push_char && len_ff <= LEN_W'(MAX_METHOD_CHARS))
               len_ff <= len_ff + 1'b1;
         end
      end
   end

   for (genvar g = 0; g < MAX_METHOD_CHARS; g++) begin : g_chars
      always_ff @(posedge clock) begin
         if (accept && !stopped_ff && push_char && len_ff == LEN_W'(g))
            chars_ff[g] <= c;
      end
   end

endmodule

@@ rtl/core/hrlp_queue.sv @@
`include "assert_macros.svh"

module hrlp_queue
   import hrlp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head_entry,
   output logic      head_valid,
   output logic      full
);

   entry_type         slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, rd_ff;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slots_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop) rd_ff <= rd_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slots_ff[wr_ff] <= push_entry;
   end

   `HRLP_ASSERT(a_no_push_full, !(push && full), "request pushed into full queue")
   `HRLP_ASSERT(a_count_bound, count_ff <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")
   `HRLP_ASSERT(a_pop_only, (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 1'b1), "pop did not drain")
   `HRLP_ASSERT(a_entry_count, head_valid |-> (head_entry.count != 2'd0), "empty token run queued")

endmodule

@@ rtl/core/hrlp_back.sv @@
module hrlp_back
   import hrlp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  entry_type  head_entry,
   input  logic       head_valid,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_token_kind,
   output logic [7:0] rsp_token_byte,
   output logic [3:0] rsp_method_code,
   output logic [7:0] rsp_version_major,
   output logic [7:0] rsp_version_minor,
   output logic [1:0] rsp_parse_status,
   output logic       rsp_last_of_run
);

   logic [1:0] idx_ff;
   logic       take;

   assign rsp_valid         = head_valid;
   assign take              = head_valid && !rsp_stall;
   assign rsp_token_kind    = head_entry.kinds[idx_ff];
   assign rsp_token_byte    = head_entry.bytes[idx_ff];
   assign rsp_method_code   = head_entry.method_code;
   assign rsp_version_major = head_entry.major;
   assign rsp_version_minor = head_entry.minor;
   assign rsp_parse_status  = head_entry.status;
   assign rsp_last_of_run   = (idx_ff == head_entry.count - 2'd1);
   assign pop               = take && rsp_last_of_run;

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= 2'd0;
      else if (take) idx_ff <= rsp_last_of_run ? 2'd0 : idx_ff + 2'd1;
   end

endmodule

@@ rtl/core/http_request_line_header_parser.sv @@
// A request byte's tokens are registered in the queue before reaching the output.
// One byte per cycle unless the queue is full; a byte's tokens leave one at a time.
// A four-entry queue between parser and token sequencer absorbs percent flushes.
// Reset (synchronous, active high) returns the parser to the start of a request
// and empties the queue; no clearing pass is needed.
module http_request_line_header_parser
   import hrlp_pkg::*;
#(
   parameter int MAX_METHOD_CHARS = 7
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_request,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_token_kind,
   output logic [7:0] rsp_token_byte,
   output logic [3:0] rsp_method_code,
   output logic [7:0] rsp_version_major,
   output logic [7:0] rsp_version_minor,
   output logic [1:0] rsp_parse_status,
   output logic       rsp_last_of_run
);

   entry_type push_entry, head_entry;
   logic      push_valid, full, head_valid, pop;

   hrlp_front #(.MAX_METHOD_CHARS(MAX_METHOD_CHARS)) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_end_of_request (req_end_of_request),
      .queue_full         (full),
      .push_valid         (push_valid),
      .push_entry         (push_entry)
   );

   hrlp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .head_valid (head_valid),
      .full       (full)
   );

   hrlp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_entry        (head_entry),
      .head_valid        (head_valid),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_token_byte    (rsp_token_byte),
      .rsp_method_code   (rsp_method_code),
      .rsp_version_major (rsp_version_major),
      .rsp_version_minor (rsp_version_minor),
      .rsp_parse_status  (rsp_parse_status),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule
